// ===== rtl/biou_pkg.sv =====
package biou_pkg;

    localparam int IN_W   = 16;
    localparam int DIFF_W = IN_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int UNI_W  = PROD_W + 2;
    localparam int MAG_W  = 32;
    localparam int DEN_W  = 34;
    localparam int FRAC_W = 15;
    localparam int QUO_W  = 16;
    localparam int DIV_W  = DEN_W + QUO_W - 1;
    localparam int OUT_W  = 16;

    localparam logic [OUT_W-1:0] ONE_Q15  = OUT_W'(32768);
    localparam logic [OUT_W-1:0] ZERO_Q15 = '0;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_DIV,
        K_SAT_ONE,
        K_SAT_ZERO
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } t_job;

endpackage

// ===== rtl/biou_front.sv =====
module biou_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [biou_pkg::IN_W-1:0]     i_a_left,
    input  logic signed [biou_pkg::IN_W-1:0]     i_a_top,
    input  logic signed [biou_pkg::IN_W-1:0]     i_a_right,
    input  logic signed [biou_pkg::IN_W-1:0]     i_a_bottom,
    input  logic signed [biou_pkg::IN_W-1:0]     i_b_left,
    input  logic signed [biou_pkg::IN_W-1:0]     i_b_top,
    input  logic signed [biou_pkg::IN_W-1:0]     i_b_right,
    input  logic signed [biou_pkg::IN_W-1:0]     i_b_bottom,
    output logic                                 o_push,
    input  logic                                 i_full,
    output biou_pkg::t_job                       o_job
);
    import biou_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [DIFF_W-1:0] n_wa, n_ha, n_wb, n_hb, n_wi, n_hi;
    logic signed [DIFF_W-1:0] r_wa, r_ha, r_wb, r_hb, r_wi, r_hi;
    logic signed [IN_W-1:0]   min_r, max_l, min_b, max_t;
    logic                     n_disj, r_disj;

    logic signed [PROD_W-1:0] n_aa, n_ab, n_ii;
    logic signed [PROD_W-1:0] r_aa, r_ab, r_ii;

    logic signed [UNI_W-1:0]  uni;
    logic [PROD_W-1:0]        mag_full;
    logic                     uni_pos;
    logic                     big;
    t_job                     n_job, r_job;

    assign en      = !r_v3 || !i_full;
    assign o_stall = !en;
    assign o_push  = r_v3 && !i_full;
    assign o_job   = r_job;

    always_comb begin
        min_r  = (i_a_right < i_b_right) ? i_a_right : i_b_right;
        max_l  = (i_a_left > i_b_left) ? i_a_left : i_b_left;
        min_b  = (i_a_bottom < i_b_bottom) ? i_a_bottom : i_b_bottom;
        max_t  = (i_a_top > i_b_top) ? i_a_top : i_b_top;
        n_wa   = DIFF_W'(i_a_right) - DIFF_W'(i_a_left);
        n_ha   = DIFF_W'(i_a_bottom) - DIFF_W'(i_a_top);
        n_wb   = DIFF_W'(i_b_right) - DIFF_W'(i_b_left);
        n_hb   = DIFF_W'(i_b_bottom) - DIFF_W'(i_b_top);
        n_wi   = DIFF_W'(min_r) - DIFF_W'(max_l);
        n_hi   = DIFF_W'(min_b) - DIFF_W'(max_t);
        n_disj = (i_a_right < i_b_left) || (i_a_left > i_b_right) ||
                 (i_a_bottom < i_b_top) || (i_a_top > i_b_bottom);
    end

    always_comb begin
        n_aa = PROD_W'(r_wa) * PROD_W'(r_ha);
        n_ab = PROD_W'(r_wb) * PROD_W'(r_hb);
        n_ii = r_disj ? '0 : PROD_W'(r_wi) * PROD_W'(r_hi);
    end

    always_comb begin
        uni      = UNI_W'(r_aa) + UNI_W'(r_ab) - UNI_W'(r_ii);
        mag_full = r_ii[PROD_W-1] ? PROD_W'(-r_ii) : PROD_W'(r_ii);
        uni_pos  = !uni[UNI_W-1] && (uni != '0);
        n_job.neg  = r_ii[PROD_W-1];
        n_job.mag  = mag_full[MAG_W-1:0];
        n_job.den  = uni[DEN_W-1:0];
        big = {{(DEN_W + 1 - MAG_W){1'b0}}, n_job.mag} >= {n_job.den, 1'b0};
        if (!uni_pos) begin
            n_job.kind = K_SAT_ONE;
        end else if (big) begin
            n_job.kind = n_job.neg ? K_SAT_ONE : K_SAT_ZERO;
        end else begin
            n_job.kind = K_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wa   <= n_wa;
            r_ha   <= n_ha;
            r_wb   <= n_wb;
            r_hb   <= n_hb;
            r_wi   <= n_wi;
            r_hi   <= n_hi;
            r_disj <= n_disj;
            r_aa   <= n_aa;
            r_ab   <= n_ab;
            r_ii   <= n_ii;
            r_job  <= n_job;
        end
    end

endmodule

// ===== rtl/biou_queue.sv =====
module biou_queue #(
    parameter int DEPTH = biou_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  biou_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output biou_pkg::t_job o_data
);
    import biou_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/biou_div.sv =====
module biou_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  biou_pkg::t_job                i_job,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [biou_pkg::OUT_W-1:0]    o_distance,
    output logic                          o_degenerate
);
    import biou_pkg::*;

    logic en;

    logic             r_v    [QUO_W+1];
    logic [DIV_W-1:0] r_rem  [QUO_W+1];
    logic [DEN_W-1:0] r_den  [QUO_W+1];
    logic [QUO_W-1:0] r_quo  [QUO_W+1];
    logic             r_neg  [QUO_W+1];
    t_kind            r_kind [QUO_W+1];

    logic [DIV_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];

    logic             r_out_v;
    logic [OUT_W-1:0] r_dist, n_dist;
    logic             r_flag, n_flag;
    logic [QUO_W-1:0] q;

    assign en           = !(r_out_v && i_stall);
    assign o_pop        = en && !i_empty;
    assign o_valid      = r_out_v;
    assign o_distance   = r_dist;
    assign o_degenerate = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= DIV_W'({i_job.mag, {FRAC_W{1'b0}}});
            r_den[0]  <= i_job.den;
            r_quo[0]  <= '0;
            r_neg[0]  <= i_job.neg;
            r_kind[0] <= i_job.kind;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             ge;

        always_comb begin
            dsh      = DIV_W'(r_den[k]) << SH;
            ge       = r_rem[k] >= dsh;
            n_rem[k] = ge ? r_rem[k] - dsh : r_rem[k];
            n_quo[k] = r_quo[k];
            n_quo[k][SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k+1]  <= n_rem[k];
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= n_quo[k];
                r_neg[k+1]  <= r_neg[k];
                r_kind[k+1] <= r_kind[k];
            end
        end
    end

    always_comb begin
        q = r_quo[QUO_W];
        case (r_kind[QUO_W])
            K_DIV: begin
                if (r_neg[QUO_W]) begin
                    n_dist = ONE_Q15;
                    n_flag = q != '0;
                end else if (q > ONE_Q15) begin
                    n_dist = ZERO_Q15;
                    n_flag = 1'b1;
                end else begin
                    n_dist = ONE_Q15 - q;
                    n_flag = 1'b0;
                end
            end
            K_SAT_ZERO: begin
                n_dist = ZERO_Q15;
                n_flag = 1'b1;
            end
            default: begin
                n_dist = ONE_Q15;
                n_flag = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= n_dist;
            r_flag <= n_flag;
        end
    end

endmodule

// ===== rtl/box_iou_distance.sv =====
// Throughput is one word per cycle when nothing stalls, set by the 16-stage
// pipelined divider, one quotient bit per stage, behind a three-stage area
// and union front end. A small queue decouples the front end from the divider
// pipeline. Synchronous active-low reset empties the pipelines and the queue.
module box_iou_distance #(
    parameter int QUEUE_DEPTH = biou_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [biou_pkg::IN_W-1:0]  i_a_left,
    input  logic signed [biou_pkg::IN_W-1:0]  i_a_top,
    input  logic signed [biou_pkg::IN_W-1:0]  i_a_right,
    input  logic signed [biou_pkg::IN_W-1:0]  i_a_bottom,
    input  logic signed [biou_pkg::IN_W-1:0]  i_b_left,
    input  logic signed [biou_pkg::IN_W-1:0]  i_b_top,
    input  logic signed [biou_pkg::IN_W-1:0]  i_b_right,
    input  logic signed [biou_pkg::IN_W-1:0]  i_b_bottom,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [biou_pkg::OUT_W-1:0]        o_distance,
    output logic                              o_degenerate
);
    import biou_pkg::*;

    logic push, full, pop, empty;
    t_job job_in, job_out;

    biou_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_right  (i_a_right),
        .i_a_bottom (i_a_bottom),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_right  (i_b_right),
        .i_b_bottom (i_b_bottom),
        .o_push     (push),
        .i_full     (full),
        .o_job      (job_in)
    );

    biou_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (job_out)
    );

    biou_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_job        (job_out),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_distance   (o_distance),
        .o_degenerate (o_degenerate)
    );

endmodule
